### rtl/core/cpht_pkg.sv
// ----------------------------------------------------------------------------
// cpht_pkg: shared constants for the circle polygon hit test
// Holds the edge count and the shape kind codes carried in tuser.
// ----------------------------------------------------------------------------
package cpht_pkg;

   localparam int NUM_EDGES = 5;

   // shape kinds carried in tuser
   localparam logic SHAPE_TRI  = 1'b0;
   localparam logic SHAPE_QUAD = 1'b1;

endpackage

### rtl/core/circle_polygon_hit_test.sv
// ----------------------------------------------------------------------------
// circle_polygon_hit_test: circle versus triangle or quadrilateral test
// Front stage forms edge vectors; back pipeline evaluates hits.
// ----------------------------------------------------------------------------
//   channel | dir | tdata                         | tuser
//   req     | in  | v1x..v4y, cx, cy, radius      | shape kind
//   rsp     | out | hit                           | -
//
// one item per cycle unless rsp stalls; passes front, stage 1, stage 2, output regs.
// reset clears all valid flags; payload registers are not reset.
// every stage holds while the next is full, so either side may stall freely.
module circle_polygon_hit_test #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // vert1_x, vert1_y, ..., vert4_y, center_x, center_y, radius
   input  logic [11*COORD_WIDTH-1:0]  req_tdata,
   // shape kind
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit
   output logic [7:0]                 rsp_tdata
);
   import cpht_pkg::*;

   localparam int CW = COORD_WIDTH;
   // the scale cancels in every comparison; fraction bits only document it
   localparam int FB_UNUSED = FRAC_BITS;

   logic signed [3:0][1:0][CW-1:0] vert;
   logic signed [1:0][CW-1:0] center;
   logic [CW-1:0] radius;

   always_comb begin
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 2; k++)
            vert[i][k] = req_tdata[(2*i+k)*CW +: CW];
      center[0] = req_tdata[8*CW +: CW];
      center[1] = req_tdata[9*CW +: CW];
      radius    = req_tdata[10*CW +: CW];
   end

   logic q_valid, q_ready, q_quad;
   logic signed [NUM_EDGES-1:0][1:0][CW:0] q_ab, q_ap, q_bp;
   logic [CW-1:0] q_radius;
   logic hit;

   cpht_front #(.CW(CW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .quad(req_tuser), .vert, .center, .radius,
      .out_valid(q_valid), .out_ready(q_ready), .out_quad(q_quad),
      .out_ab(q_ab), .out_ap(q_ap), .out_bp(q_bp), .out_radius(q_radius)
   );

   cpht_back #(.CW(CW)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .quad(q_quad),
      .ab(q_ab), .ap(q_ap), .bp(q_bp), .radius(q_radius),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_hit(hit)
   );

   assign rsp_tdata = {7'(FB_UNUSED * 0), hit};
endmodule

### rtl/core/cpht_front.sv
// ----------------------------------------------------------------------------
// cpht_front: edge vector stage
// Accepts a request, forms edge and centre-offset vectors and registers them.
// ----------------------------------------------------------------------------
module cpht_front #(
   parameter int CW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          quad,
   input  logic signed [3:0][1:0][CW-1:0] vert,
   input  logic signed [1:0][CW-1:0]     center,
   input  logic [CW-1:0]                 radius,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_quad,
   output logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] out_ab,
   output logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] out_ap,
   output logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] out_bp,
   output logic [CW-1:0]                 out_radius
);
   import cpht_pkg::*;

   // edge endpoints: v1v2, v2v3, v3v1, v1v4, v4v3
   localparam int EA [NUM_EDGES] = '{0, 1, 2, 0, 3};
   localparam int EB [NUM_EDGES] = '{1, 2, 0, 3, 2};

   logic valid_ff;
   logic quad_ff;
   logic signed [NUM_EDGES-1:0][1:0][CW:0] ab_ff, ap_ff, bp_ff;
   logic [CW-1:0] radius_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         quad_ff   <= quad;
         radius_ff <= radius;
         for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < 2; k++) begin
               // packed elements select unsigned, so sign-extend explicitly
               ab_ff[e][k] <= (CW+1)'($signed(vert[EA[e]][k]))
                              - (CW+1)'($signed(vert[EB[e]][k]));
               ap_ff[e][k] <= (CW+1)'($signed(vert[EA[e]][k]))
                              - (CW+1)'($signed(center[k]));
               bp_ff[e][k] <= (CW+1)'($signed(vert[EB[e]][k]))
                              - (CW+1)'($signed(center[k]));
            end
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_quad   = quad_ff;
   assign out_ab     = ab_ff;
   assign out_ap     = ap_ff;
   assign out_bp     = bp_ff;
   assign out_radius = radius_ff;
endmodule

### rtl/core/cpht_back.sv
// ----------------------------------------------------------------------------
// cpht_back: edge evaluation pipeline
// Products, then squares and sign tests, then the hit decision and output
// register.
// ----------------------------------------------------------------------------
module cpht_back #(
   parameter int CW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          quad,
   input  logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] ab,
   input  logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] ap,
   input  logic signed [cpht_pkg::NUM_EDGES-1:0][1:0][CW:0] bp,
   input  logic [CW-1:0]                 radius,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_hit
);
   import cpht_pkg::*;

   localparam int PW = 2*CW + 3;   // product / cross / dot width
   localparam int SW = 2*PW;       // squared terms

   // stage 1: products
   logic s1_valid_ff, s1_quad_ff;
   logic signed [NUM_EDGES-1:0][PW-1:0] len2_ff, cr_ff, d1_ff, d2_ff;
   logic [2*CW-1:0] r2_ff;
   // stage 2: comparisons
   logic s2_valid_ff, s2_quad_ff;
   logic [NUM_EDGES-1:0] edge_ff, pos_ff, neg_ff;
   // output register
   logic out_valid_ff, hit_ff;

   logic s2_ready, s1_ready;
   logic [NUM_EDGES-1:0] edge_in, pos_in, neg_in;
   logic hit_in;

   assign s2_ready = !out_valid_ff || out_ready;
   assign s1_ready = !s2_valid_ff || s2_ready;
   assign in_ready = !s1_valid_ff || s1_ready;

   always_comb begin
      logic signed [SW-1:0] lhs, rhs;
      logic s1n, s1z, s2n, s2z;
      for (int e = 0; e < NUM_EDGES; e++) begin
         lhs = SW'(signed'({1'b0, r2_ff})) * SW'($signed(len2_ff[e]));
         rhs = SW'($signed(cr_ff[e])) * SW'($signed(cr_ff[e]));
         s1n = d1_ff[e][PW-1];
         s1z = d1_ff[e] == '0;
         s2n = d2_ff[e][PW-1];
         s2z = d2_ff[e] == '0;
         // zero-length edges never hit; projection: signs differ or one is zero
         edge_in[e] = (len2_ff[e] != '0) && !(lhs < rhs)
                      && (s1z || s2z || (s1n != s2n));
         pos_in[e]  = !cr_ff[e][PW-1] && (cr_ff[e] != '0);
         neg_in[e]  = cr_ff[e][PW-1];
      end
      hit_in = (|edge_ff[2:0]) || (&pos_ff[2:0]) || (&neg_ff[2:0]);
      // second triangle uses v1v4, v4v3 and the shared diagonal v3v1
      if (s2_quad_ff == SHAPE_QUAD) begin
         hit_in = hit_in || (|edge_ff[4:3])
                  || (pos_ff[3] && pos_ff[4] && pos_ff[2])
                  || (neg_ff[3] && neg_ff[4] && neg_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready)  s1_valid_ff  <= in_valid;
         if (s1_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s2_ready)  out_valid_ff <= s2_valid_ff;
      end
      if (in_ready && in_valid) begin
         s1_quad_ff <= quad;
         r2_ff <= (2*CW)'(radius) * (2*CW)'(radius);
         for (int e = 0; e < NUM_EDGES; e++) begin
            len2_ff[e] <= PW'($signed(ab[e][0])) * PW'($signed(ab[e][0]))
                          + PW'($signed(ab[e][1])) * PW'($signed(ab[e][1]));
            cr_ff[e]   <= PW'($signed(ab[e][0])) * PW'($signed(ap[e][1]))
                          - PW'($signed(ab[e][1])) * PW'($signed(ap[e][0]));
            d1_ff[e]   <= PW'($signed(ab[e][0])) * PW'($signed(ap[e][0]))
                          + PW'($signed(ab[e][1])) * PW'($signed(ap[e][1]));
            d2_ff[e]   <= PW'($signed(bp[e][0])) * PW'($signed(ab[e][0]))
                          + PW'($signed(bp[e][1])) * PW'($signed(ab[e][1]));
         end
      end
      if (s1_ready && s1_valid_ff) begin
         s2_quad_ff <= s1_quad_ff;
         edge_ff    <= edge_in;
         pos_ff     <= pos_in;
         neg_ff     <= neg_in;
      end
      if (s2_ready && s2_valid_ff) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = hit_ff;
endmodule

### tb/circle_polygon_hit_test_tb.sv
// ----------------------------------------------------------------------------
// circle_polygon_hit_test_tb: self-checking bench for the hit test
// Streams random and corner-case circle/polygon queries through the block
// under varied idling, predicts each hit flag with exact integer geometry and
// compares the hit bit of every response word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_polygon_hit_test_tb;
   import cpht_pkg::*;

   localparam int CW      = 16;
   localparam int LATENCY = 4;

   typedef struct packed {
      logic            shape;
      logic [3:0][1:0][CW-1:0] vert;   // [vertex][0=x,1=y]
      logic [CW-1:0]   cx;
      logic [CW-1:0]   cy;
      logic [CW-1:0]   radius;
   } query_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [11*CW-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [7:0]       rsp_tdata;

   circle_polygon_hit_test dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   query_type pending_q[$];
   query_type pending_cur;
   logic   hit_q[$];
   bit     failed;
   int     send_idle_pct;
   int     recv_stall_pct;
   int     hold_off;
   bit     sender_pause;
   int     sent_count;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- geometry
   typedef logic signed [95:0] wide_type;

   function automatic wide_type cross_of(wide_type ax, wide_type ay, wide_type bx,
                                         wide_type by, wide_type px, wide_type py);
      return (ax - bx) * (ay - py) - (ay - by) * (ax - px);
   endfunction

   function automatic bit edge_touch(wide_type ax, wide_type ay, wide_type bx,
                                     wide_type by, wide_type px, wide_type py,
                                     wide_type r2);
      wide_type abx, aby, len2, cr, d1, d2;
      abx  = ax - bx;
      aby  = ay - by;
      len2 = abx * abx + aby * aby;
      if (len2 == 0) return 1'b0;
      cr = cross_of(ax, ay, bx, by, px, py);
      if (r2 * len2 < cr * cr) return 1'b0;
      d1 = abx * (ax - px) + aby * (ay - py);
      d2 = (bx - px) * abx + (by - py) * aby;
      return (d1 == 0) || (d2 == 0) || ((d1 < 0) != (d2 < 0));
   endfunction

   function automatic bit tri_touch(wide_type x1, wide_type y1, wide_type x2,
                                    wide_type y2, wide_type x3, wide_type y3,
                                    wide_type px, wide_type py, wide_type r2);
      wide_type c1, c2, c3;
      if (edge_touch(x1, y1, x2, y2, px, py, r2)) return 1'b1;
      if (edge_touch(x2, y2, x3, y3, px, py, r2)) return 1'b1;
      if (edge_touch(x3, y3, x1, y1, px, py, r2)) return 1'b1;
      c1 = cross_of(x1, y1, x2, y2, px, py);
      c2 = cross_of(x2, y2, x3, y3, px, py);
      c3 = cross_of(x3, y3, x1, y1, px, py);
      return (c1 > 0 && c2 > 0 && c3 > 0) || (c1 < 0 && c2 < 0 && c3 < 0);
   endfunction

   function automatic logic predict_hit(query_type q);
      wide_type vx[4], vy[4], px, py, rr;
      bit    h;
      for (int i = 0; i < 4; i++) begin
         vx[i] = wide_type'($signed(q.vert[i][0]));
         vy[i] = wide_type'($signed(q.vert[i][1]));
      end
      px = wide_type'($signed(q.cx));
      py = wide_type'($signed(q.cy));
      rr = wide_type'({1'b0, q.radius});
      rr = rr * rr;
      h = tri_touch(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], px, py, rr);
      if (!h && q.shape == SHAPE_QUAD)
         h = tri_touch(vx[0], vy[0], vx[3], vy[3], vx[2], vy[2], px, py, rr);
      return h;
   endfunction

   function automatic logic [11*CW-1:0] pack_query(query_type q);
      logic [11*CW-1:0] d;
      for (int i = 0; i < 4; i++) begin
         d[(2*i)*CW +: CW]   = q.vert[i][0];
         d[(2*i+1)*CW +: CW] = q.vert[i][1];
      end
      d[8*CW +: CW]  = q.cx;
      d[9*CW +: CW]  = q.cy;
      d[10*CW +: CW] = q.radius;
      return d;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic logic [CW-1:0] rand_coord(int span);
      int v;
      if (span == 0) return CW'($urandom);
      v = $urandom_range(2 * span) - span;
      return CW'(v);
   endfunction

   function automatic query_type rand_query();
      query_type q;
      int span, cxv, cyv;
      case ($urandom_range(9))
         0: span = 0;
         1, 2: span = 64;
         3, 4, 5: span = 2000;
         default: span = 30000;
      endcase
      q.shape = 1'($urandom_range(1));
      for (int i = 0; i < 4; i++) begin
         q.vert[i][0] = rand_coord(span);
         q.vert[i][1] = rand_coord(span);
      end
      // centre near the shape most of the time so both outcomes occur
      if ($urandom_range(3) != 0 && span != 0) begin
         cxv = $signed(q.vert[$urandom_range(3)][0]);
         cyv = $signed(q.vert[$urandom_range(3)][1]);
         cxv = (cxv + $signed(q.vert[$urandom_range(2)][0])) / 2;
         cyv = (cyv + $signed(q.vert[$urandom_range(2)][1])) / 2;
         q.cx = CW'(cxv);
         q.cy = CW'(cyv);
      end else begin
         q.cx = rand_coord(span);
         q.cy = rand_coord(span);
      end
      // degenerate shapes and zero-length edges
      if ($urandom_range(9) == 0) q.vert[1] = q.vert[0];
      if ($urandom_range(14) == 0) q.vert[3] = q.vert[2];
      if ($urandom_range(19) == 0) q.vert[2] = q.vert[0];
      case ($urandom_range(5))
         0: q.radius = 16'd0;
         1: q.radius = 16'hFFFF;
         2: q.radius = CW'($urandom);
         default: q.radius = CW'($urandom_range(span == 0 ? 4000 : span / 2 + 1));
      endcase
      return q;
   endfunction

   function automatic query_type mk(logic shape, int x1, int y1, int x2, int y2,
                                    int x3, int y3, int x4, int y4,
                                    int cxv, int cyv, int r);
      query_type q;
      q.shape = shape;
      q.vert[0][0] = CW'(x1); q.vert[0][1] = CW'(y1);
      q.vert[1][0] = CW'(x2); q.vert[1][1] = CW'(y2);
      q.vert[2][0] = CW'(x3); q.vert[2][1] = CW'(y3);
      q.vert[3][0] = CW'(x4); q.vert[3][1] = CW'(y4);
      q.cx = CW'(cxv); q.cy = CW'(cyv); q.radius = CW'(r);
      return q;
   endfunction

   task automatic load_directed();
      // inside, outside, touching edge, zero radius, extremes
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, 160, 0, 0, 32, 32, 0));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 0, 160, 160, 0, 0, 0, 32, 32, 0));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, 160, 0, 0, 80, -16, 16));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, 160, 0, 0, 80, -17, 16));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, 160, 0, 0, 200, 0, 16));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, 160, 9, 9, 80, 0, 0));
      // zero-length edge and fully degenerate triangle
      pending_q.push_back(mk(SHAPE_TRI, 50, 50, 50, 50, 50, 50, 0, 0, 50, 50, 65535));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 0, 0, 160, 0, 0, 0, 80, 10, 10));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 80, 0, 160, 0, 0, 0, 80, 5, 4));
      // triangle ignores vertex 4; quad picks it up
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 160, 160, 0, 160, 16, 120, 2));
      pending_q.push_back(mk(SHAPE_QUAD, 0, 0, 160, 0, 160, 160, 0, 160, 16, 120, 2));
      pending_q.push_back(mk(SHAPE_QUAD, 0, 0, 160, 0, 160, 160, 0, 160, 400, 400, 3));
      // coordinate extremes
      pending_q.push_back(mk(SHAPE_QUAD, -32768, -32768, 32767, -32768, 32767, 32767,
                             -32768, 32767, 0, 0, 0));
      pending_q.push_back(mk(SHAPE_QUAD, -32768, -32768, 32767, -32768, 32767, 32767,
                             -32768, 32767, -32768, 0, 0));
      pending_q.push_back(mk(SHAPE_TRI, -32768, -32768, 32767, 32767, -32768, 32767,
                             -1, -1, 32767, -32768, 65535));
      pending_q.push_back(mk(SHAPE_TRI, -32768, -32768, 32767, 32767, -32768, 32767,
                             -1, -1, 32767, -32768, 1));
      pending_q.push_back(mk(SHAPE_QUAD, 32767, 32767, 32767, 32767, 32767, 32767,
                             -32768, -32768, -32768, -32768, 0));
      pending_q.push_back(mk(SHAPE_QUAD, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 65535));
      // projection just past an edge end
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, -160, 0, 0, 170, 3, 5));
      pending_q.push_back(mk(SHAPE_TRI, 0, 0, 160, 0, 0, -160, 0, 0, 160, 3, 3));
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) sent_count <= sent_count + 1;
         if (req_tvalid) hit_q.push_back(predict_hit(pending_cur));
         if (pending_q.size() != 0 && !sender_pause &&
             $urandom_range(99) >= send_idle_pct) begin
            pending_cur = pending_q.pop_front();
            req_tdata  <= pack_query(pending_cur);
            req_tuser  <= pending_cur.shape;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_q.size() == 0) begin
            $error("unexpected response word, hit=%0d", rsp_tdata[0]);
            failed = 1'b1;
         end else begin
            want = hit_q.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("hit mismatch: expected %0d actual %0d", want, rsp_tdata[0]);
               failed = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   // sampled mid-cycle so the driver's updates at the edge have settled
   task automatic drain();
      while (pending_q.size() != 0 || req_tvalid || hit_q.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) pending_q.push_back(rand_query());
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      hold_off     = 0;
      sender_pause = 1'b0;
      sent_count   = 0;
      failed       = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      drain();
      run_phase(0, 0, 450);
      run_phase(55, 0, 400);
      run_phase(0, 55, 400);
      run_phase(27, 27, 300);

      // long receiver hold-off while the sender keeps offering words
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_off <= 60;
      for (int i = 0; i < 150; i++) pending_q.push_back(rand_query());
      drain();

      // sender pauses until every response is back
      sender_pause <= 1'b1;
      drain();
      repeat (LATENCY + 4) @(posedge clock);
      sender_pause <= 1'b0;
      run_phase(27, 27, 150);

      repeat (LATENCY + 10) @(posedge clock);
      if (!failed && hit_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
rtl/core/cpht_pkg.sv
rtl/core/cpht_front.sv
rtl/core/cpht_back.sv
rtl/core/circle_polygon_hit_test.sv
tb/circle_polygon_hit_test_tb.sv
